FILE: hw/rtl/wcc_pkg.sv
// Shared types and constants for the 2-D window cross-correlation unit.
// No dependencies; the interfaces and the top level import it.
package wcc_pkg;

	// Payload field widths
	localparam int OPCODE_W = 2;
	localparam int COORD_W  = 7;
	localparam int VALUE_W  = 16;
	localparam int RESULT_W = 32;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int DIM_W       = 8;
	localparam int KSZ_W       = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_ROWS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_COLS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SIZE = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_NORMALIZE   = 2'd3;

	localparam int ROWS_RESET  = 128;
	localparam int COLS_RESET  = 128;
	localparam int KSIZE_RESET = 3;

	// Q2.14 coefficients: product is Q10.22, result Q24.8
	localparam int FRAC_SHIFT = 14;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

	localparam logic [RESULT_W-1:0] RES_MAX = 32'h7FFF_FFFF;
	localparam logic [RESULT_W-1:0] RES_MIN = 32'h8000_0000;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD_KERNEL = 2'd0,
		OP_LOAD_PIXEL  = 2'd1,
		OP_QUERY       = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_PREP,
		ST_DIV,
		ST_SAT,
		ST_EMIT
	} state_t;

endpackage

FILE: hw/rtl/wcc_ifs.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on wcc_pkg.
interface wcc_req_if;
	import wcc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OPCODE_W-1:0]       opcode;
	logic [COORD_W-1:0]        row;
	logic [COORD_W-1:0]        col;
	logic signed [VALUE_W-1:0] value;
	modport source (output valid, opcode, row, col, value, input ready);
	modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface wcc_rsp_if;
	import wcc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [RESULT_W-1:0] filtered_value;
	logic                       zero_divisor;
	modport source (output valid, filtered_value, zero_divisor, input ready);
	modport sink   (input valid, filtered_value, zero_divisor, output ready);
endinterface

FILE: hw/rtl/wcc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module wcc_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/window_cross_correlation_2d_unit.sv
// Top level of the 2-D window cross-correlation unit: stores, MAC walk, divider.
// Depends on wcc_pkg, wcc_ifs (wcc_req_if, wcc_rsp_if) and wcc_ram.
//
// Channel  Dir  Payload                             Beat taken when
// -------  ---  ----------------------------------  ----------------------
// req      in   opcode, row, col, value             req.valid & req.ready
// rsp      out  filtered_value, zero_divisor        rsp.valid & rsp.ready
// cfg      in   cfg_index, cfg_data                 cfg_we
//
// Loads may follow back to back while the block is idle. A query walks its
// clipped window (P pairs, at most MAX_KERNEL^2) through one MAC, one pair a
// cycle from the two RAM read ports; a normalised query then runs the
// one-bit-a-cycle restoring divider for DIV_W (41 by default) steps. The block
// takes one item at a time. Reset clears control and configuration only;
// RAM contents are undefined until loaded. A stalled result sits in the
// output register while the next item is taken; a further result waits in
// the last state until it frees.
module window_cross_correlation_2d_unit #(
	parameter int MAX_ROWS   = 128,
	parameter int MAX_COLS   = 128,
	parameter int MAX_KERNEL = 9
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wcc_pkg::CFG_DATA_W-1:0]  cfg_data,
	wcc_req_if.sink                         req,
	wcc_rsp_if.source                       rsp
);

	import wcc_pkg::*;

	// Store geometry
	localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int IMG_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KRN_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int KRN_AW    = (KRN_DEPTH > 1) ? $clog2(KRN_DEPTH) : 1;
	localparam int KC_W      = $clog2(MAX_KERNEL + 1);

	// Window arithmetic: coordinates plus/minus half a kernel, kept unsigned
	localparam int SW = DIM_W + 2;

	// Accumulator and divider widths, exact for a full window
	localparam int ACC_W  = 2 * VALUE_W + $clog2(KRN_DEPTH + 1);
	localparam int CSUM_W = VALUE_W + $clog2(KRN_DEPTH + 1);
	localparam int DIV_W  = ACC_W + 2;
	localparam int DEN_W  = CSUM_W + 1;
	localparam int DCNT_W = $clog2(DIV_W + 1);

	localparam int ROWS_RST  = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
	localparam int COLS_RST  = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
	localparam int KSIZE_RST = (KSIZE_RESET > MAX_KERNEL) ? MAX_KERNEL : KSIZE_RESET;

	// ------------------------------------------------------------------
	// Configuration registers, clamped on write
	// ------------------------------------------------------------------
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [KSZ_W-1:0] ksize_q;
	logic             norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_W'(ROWS_RST);
			cols_q  <= DIM_W'(COLS_RST);
			ksize_q <= KSZ_W'(KSIZE_RST);
			norm_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_ROWS: begin
					if (cfg_data == '0)
						rows_q <= DIM_W'(1);
					else if (32'(cfg_data) > MAX_ROWS)
						rows_q <= DIM_W'(MAX_ROWS);
					else
						rows_q <= cfg_data;
				end
				CFG_IMAGE_COLS: begin
					if (cfg_data == '0)
						cols_q <= DIM_W'(1);
					else if (32'(cfg_data) > MAX_COLS)
						cols_q <= DIM_W'(MAX_COLS);
					else
						cols_q <= cfg_data;
				end
				CFG_KERNEL_SIZE: begin
					if (cfg_data[KSZ_W-1:0] == '0)
						ksize_q <= KSZ_W'(1);
					else if (32'(cfg_data[KSZ_W-1:0]) > MAX_KERNEL)
						ksize_q <= KSZ_W'(MAX_KERNEL);
					else
						ksize_q <= cfg_data[KSZ_W-1:0];
				end
				CFG_NORMALIZE: begin
					norm_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic             req_beat;
	logic             query_ok;
	logic             issue;
	logic             last_pair;
	logic             row_end;
	logic             emit;

	logic [COORD_W-1:0] qrow_q, qcol_q;
	logic [IMG_AW-1:0]  img_row_q;
	logic [KRN_AW-1:0]  krn_row_q;
	logic [KC_W-1:0]    nrows_q, ncols_q;
	logic [KC_W-1:0]    a_q, b_q;

	logic v_s1, last_s1, v_s2, last_s2;

	logic [DCNT_W-1:0] dcnt_q;

	logic signed [CSUM_W-1:0] csum_q;

	logic rsp_valid_q;

	assign req_beat = req.valid && req.ready;
	assign query_ok = (req.opcode == OP_QUERY) && ({1'b0, req.row} < rows_q)
		&& ({1'b0, req.col} < cols_q);
	assign row_end   = (b_q == ncols_q - KC_W'(1));
	assign last_pair = row_end && (a_q == nrows_q - KC_W'(1));

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		issue     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && query_ok)
					state_d = ST_SETUP;
			end
			ST_SETUP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_pair)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (v_s2 && last_s2)
					state_d = ST_PREP;
			end
			ST_PREP: begin
				// normalise with a non-zero divisor needs the divider
				if (norm_q && (csum_q != '0))
					state_d = ST_DIV;
				else
					state_d = ST_EMIT;
			end
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(1))
					state_d = ST_SAT;
			end
			ST_SAT: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!rsp_valid_q || rsp.ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// ------------------------------------------------------------------
	// Stores
	// ------------------------------------------------------------------
	logic                img_we, krn_we;
	logic [IMG_AW-1:0]   img_waddr, img_raddr;
	logic [KRN_AW-1:0]   krn_waddr, krn_raddr;
	logic [VALUE_W-1:0]  img_rdata, krn_rdata;

	// out-of-range loads are dropped
	assign img_we = req_beat && (req.opcode == OP_LOAD_PIXEL)
		&& (int'(req.row) < MAX_ROWS) && (int'(req.col) < MAX_COLS);
	assign krn_we = req_beat && (req.opcode == OP_LOAD_KERNEL)
		&& (int'(req.row) < MAX_KERNEL) && (int'(req.col) < MAX_KERNEL);
	assign img_waddr = IMG_AW'(int'(req.row) * MAX_COLS + int'(req.col));
	assign krn_waddr = KRN_AW'(int'(req.row) * MAX_KERNEL + int'(req.col));
	assign img_raddr = img_row_q + IMG_AW'(b_q);
	assign krn_raddr = krn_row_q + KRN_AW'(b_q);

	wcc_ram #(
		.WIDTH  (VALUE_W),
		.DEPTH  (IMG_DEPTH),
		.ADDR_W (IMG_AW)
	) u_image_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (req.value),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	wcc_ram #(
		.WIDTH  (VALUE_W),
		.DEPTH  (KRN_DEPTH),
		.ADDR_W (KRN_AW)
	) u_kernel_ram (
		.clk   (clk),
		.we    (krn_we),
		.waddr (krn_waddr),
		.wdata (req.value),
		.raddr (krn_raddr),
		.rdata (krn_rdata)
	);

	// ------------------------------------------------------------------
	// Window clipping (evaluated in SETUP)
	// ------------------------------------------------------------------
	logic [KSZ_W-1:0] half;
	logic [SW-1:0]    i0, j0, i_hi_raw, j_hi_raw, i_lo, j_lo, i_hi, j_hi, ki, kj;

	always_comb begin
		half     = ksize_q >> 1;
		i0       = SW'(qrow_q) - SW'(half);
		j0       = SW'(qcol_q) - SW'(half);
		i_hi_raw = i0 + SW'(ksize_q);
		j_hi_raw = j0 + SW'(ksize_q);
		// window starting above or left of the image: skip kernel rows/cols
		i_lo     = i0[SW-1] ? '0 : i0;
		j_lo     = j0[SW-1] ? '0 : j0;
		ki       = i0[SW-1] ? SW'(-i0) : '0;
		kj       = j0[SW-1] ? SW'(-j0) : '0;
		i_hi     = (i_hi_raw > SW'(rows_q)) ? SW'(rows_q) : i_hi_raw;
		j_hi     = (j_hi_raw > SW'(cols_q)) ? SW'(cols_q) : j_hi_raw;
	end

	// ------------------------------------------------------------------
	// Window walk and MAC pipeline
	//   issue: addresses from row bases + column counter
	//   s1:    RAM read data
	//   s2:    product registered, then accumulated
	// ------------------------------------------------------------------
	logic signed [2*VALUE_W-1:0] prod_s2;
	logic signed [VALUE_W-1:0]   kv_s2;
	logic signed [ACC_W-1:0]     acc_q;

	always_ff @(posedge clk) begin
		if (req_beat && query_ok) begin
			qrow_q <= req.row;
			qcol_q <= req.col;
		end
		case (state_q)
			ST_SETUP: begin
				img_row_q <= IMG_AW'(int'(i_lo) * MAX_COLS + int'(j_lo));
				krn_row_q <= KRN_AW'(int'(ki) * MAX_KERNEL + int'(kj));
				nrows_q   <= KC_W'(i_hi - i_lo);
				ncols_q   <= KC_W'(j_hi - j_lo);
				a_q       <= '0;
				b_q       <= '0;
			end
			ST_RUN: begin
				if (row_end) begin
					b_q       <= '0;
					a_q       <= a_q + KC_W'(1);
					img_row_q <= img_row_q + IMG_AW'(MAX_COLS);
					krn_row_q <= krn_row_q + KRN_AW'(MAX_KERNEL);
				end else begin
					b_q <= b_q + KC_W'(1);
				end
			end
			default: begin
			end
		endcase

		prod_s2 <= $signed(img_rdata) * $signed(krn_rdata);
		kv_s2   <= $signed(krn_rdata);

		if (state_q == ST_SETUP) begin
			acc_q  <= '0;
			csum_q <= '0;
		end else if (v_s2) begin
			acc_q  <= acc_q + ACC_W'(prod_s2);
			csum_q <= csum_q + CSUM_W'(kv_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= issue;
			last_s1 <= issue && last_pair;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Result: rounding shift, or restoring division by the coefficient sum
	// ------------------------------------------------------------------
	logic signed [ACC_W:0]  rnd, shf;
	logic [ACC_W-1:0]       na;
	logic [CSUM_W-1:0]      nd;
	logic [DEN_W:0]         trial;
	logic                   q_big_neg, q_big_pos;

	logic [DIV_W-1:0]       quo_q;
	logic [DEN_W-1:0]       rem_q;
	logic [DEN_W-1:0]       den_q;
	logic                   neg_q;
	logic [RESULT_W-1:0]    res_q;
	logic                   zf_q;

	always_comb begin
		rnd   = (ACC_W+1)'(acc_q) + (ACC_W+1)'(ROUND_HALF);
		shf   = rnd >>> FRAC_SHIFT;
		na    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		nd    = csum_q[CSUM_W-1] ? CSUM_W'(-csum_q) : CSUM_W'(csum_q);
		trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, den_q};
		// magnitude past 2^31 (negative side) or 2^31 - 1 (positive side)
		q_big_neg = (quo_q[DIV_W-1:RESULT_W] != '0)
			|| (quo_q[RESULT_W-1] && (quo_q[RESULT_W-2:0] != '0));
		q_big_pos = (quo_q[DIV_W-1:RESULT_W-1] != '0);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				zf_q <= 1'b0;
				if (!norm_q) begin
					if (shf[ACC_W:RESULT_W-1] != {(ACC_W-RESULT_W+2){shf[RESULT_W-1]}})
						res_q <= shf[ACC_W] ? RES_MIN : RES_MAX;
					else
						res_q <= shf[RESULT_W-1:0];
				end else if (csum_q == '0) begin
					res_q <= '0;
					zf_q  <= 1'b1;
				end else begin
					// round to nearest, ties away: (2|a| + |d|) / (2|d|)
					quo_q  <= (DIV_W'(na) << 1) + DIV_W'(nd);
					den_q  <= DEN_W'(nd) << 1;
					rem_q  <= '0;
					neg_q  <= acc_q[ACC_W-1] ^ csum_q[CSUM_W-1];
					dcnt_q <= DCNT_W'(DIV_W);
				end
			end
			ST_DIV: begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
				if (!trial[DEN_W]) begin
					rem_q <= trial[DEN_W-1:0];
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DEN_W-2:0], quo_q[DIV_W-1]};
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
			end
			ST_SAT: begin
				if (neg_q)
					res_q <= q_big_neg ? RES_MIN : RESULT_W'(0) - quo_q[RESULT_W-1:0];
				else
					res_q <= q_big_pos ? RES_MAX : quo_q[RESULT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic [RESULT_W-1:0] rsp_val_q;
	logic                rsp_zf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (emit)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_val_q <= res_q;
			rsp_zf_q  <= zf_q;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.filtered_value = rsp_val_q;
	assign rsp.zero_divisor   = rsp_zf_q;

endmodule
